// ===== rtl/cms_pkg.sv =====
`default_nettype none

package cms_pkg;

	localparam int unsigned IN_W   = 64;
	localparam int unsigned USER_W = 4;
	localparam int unsigned OUT_W  = 56;

	localparam logic [2:0] HL_SLOT = 3'd6;
	localparam logic [2:0] REG_H   = 3'd4;
	localparam logic [2:0] REG_L   = 3'd5;

	// bits that always read as one in the packed flag byte
	localparam logic [7:0] FLAG_FIXED = 8'h22;

	typedef enum logic [3:0] {
		MODE_MOV     = 4'd0,
		MODE_PUSH    = 4'd1,
		MODE_POP     = 4'd2,
		MODE_CALL    = 4'd3,
		MODE_JMP     = 4'd4,
		MODE_RST     = 4'd5,
		MODE_FLAG_LD = 4'd6,
		MODE_FLAG_RD = 4'd7,
		MODE_MEM_WR  = 4'd8,
		MODE_REG_WR  = 4'd9
	} mode_t;

	// what the second stage does with the RAM read data
	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_POP,
		KIND_TARGET,
		KIND_LOAD
	} kind_t;

	typedef struct packed {
		logic        we;
		logic [15:0] addr;
		logic [7:0]  wdata;
	} mem_req_t;

	// S Z AC P CY -> S Z 1 AC 0 P 1 CY
	function automatic logic [7:0] pack_flags(input logic [4:0] f);
		logic [7:0] b;
		b = FLAG_FIXED;
		b[7] = f[4];
		b[6] = f[3];
		b[4] = f[2];
		b[2] = f[1];
		b[0] = f[0];
		return b;
	endfunction

	function automatic logic [4:0] unpack_flags(input logic [7:0] b);
		return {b[7], b[6], b[4], b[2], b[0]};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/cms_ram.sv =====
`default_nettype none

module cms_ram #(
	parameter int unsigned ADDR_BITS = 16
) (
	input  wire logic               clk,
	input  wire cms_pkg::mem_req_t  req0,
	input  wire cms_pkg::mem_req_t  req1,
	output logic [7:0]              rdata0,
	output logic [7:0]              rdata1
);

	localparam int unsigned DEPTH = 2 ** ADDR_BITS;

	logic [7:0] mem [DEPTH];

	logic [ADDR_BITS-1:0] a0;
	logic [ADDR_BITS-1:0] a1;

	assign a0 = req0.addr[ADDR_BITS-1:0];
	assign a1 = req1.addr[ADDR_BITS-1:0];

	always_ff @(posedge clk) begin
		if (req0.we) begin
			mem[a0] <= req0.wdata;
		end
		if (req1.we) begin
			mem[a1] <= req1.wdata;
		end
		rdata0 <= mem[a0];
		rdata1 <= mem[a1];
	end

endmodule

`default_nettype wire

// ===== rtl/cms_outq.sv =====
`default_nettype none

module cms_outq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire logic [cms_pkg::OUT_W-1:0]     push_data,
	input  wire logic                          take_ready,
	output logic                               valid,
	output logic [cms_pkg::OUT_W-1:0]          data,
	output logic [1:0]                         count
);

	logic [cms_pkg::OUT_W-1:0] ent_q [2];
	logic [1:0]                cnt_q;
	logic                      take;

	assign valid = (cnt_q != 2'd0);
	assign data  = ent_q[0];
	assign count = cnt_q;
	assign take  = valid && take_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, take});
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ent_q[0] <= (cnt_q == 2'd2) ? ent_q[1] : push_data;
			if (push && cnt_q == 2'd2) begin
				ent_q[1] <= push_data;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				ent_q[0] <= push_data;
			end else begin
				ent_q[1] <= push_data;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cpu8080_move_stack_unit_core.sv =====
`default_nettype none

// 8080-style move and stack slice. Holds the register file, stack pointer and
// flags in flip-flops and the byte memory in a dual-port RAM with registered
// read data. An input transfer issues its RAM accesses in the accepting cycle;
// the result is formed in the next cycle and lands in a two-entry output queue,
// so the first result passes the stage-1 registers and then the queue. Rate is
// one item per cycle into an empty pipe while the receiver keeps up; under a
// steady stream the output queue depth holds input back. CALL and MOV from
// memory hold the input while in stage 1: CALL reads its target on both RAM
// ports and then writes the return address on both ports, and MOV from memory
// writes the loaded byte back into the register file.
module cpu8080_move_stack_unit_core #(
	parameter int unsigned ADDR_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// opcode, pc_in, data_high, data_low, restart_number, write_address,
	// reg_index, zero pad
	input  wire logic [cms_pkg::IN_W-1:0]    s_tdata,
	// mode
	input  wire logic [cms_pkg::USER_W-1:0]  s_tuser,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// pc_out, value_out, flag_byte_out, stack_pointer_out
	output logic [cms_pkg::OUT_W-1:0]        m_tdata
);

	cms_pkg::mode_t mode;
	logic [7:0]     opcode;
	logic [15:0]    pc_in;
	logic [7:0]     data_high;
	logic [7:0]     data_low;
	logic [2:0]     restart_number;
	logic [15:0]    write_address;
	logic [2:0]     reg_index;

	assign mode           = cms_pkg::mode_t'(s_tuser);
	assign opcode         = s_tdata[7:0];
	assign pc_in          = s_tdata[23:8];
	assign data_high      = s_tdata[31:24];
	assign data_low       = s_tdata[39:32];
	assign restart_number = s_tdata[42:40];
	assign write_address  = s_tdata[58:43];
	assign reg_index      = s_tdata[61:59];

	logic [7:0]  regs_q [8];
	logic [15:0] sp_q;
	logic [4:0]  flags_q;

	logic                  s1_valid_s1;
	logic                  call_s1;
	cms_pkg::kind_t        kind_s1;
	logic [2:0]            dst_s1;
	logic [15:0]           pc_s1;
	logic [15:0]           sp_s1;
	logic [7:0]            flg_s1;

	logic                  accept;
	logic                  s1_long;
	logic [1:0]            out_cnt;

	cms_pkg::mem_req_t     a_req0;
	cms_pkg::mem_req_t     a_req1;
	cms_pkg::mem_req_t     req0;
	cms_pkg::mem_req_t     req1;
	logic [7:0]            rdata0;
	logic [7:0]            rdata1;

	logic [2:0]            src;
	logic [2:0]            dst;
	logic [15:0]           hl;
	logic [15:0]           sp_nxt;
	logic [4:0]            flg_nxt;
	logic                  rf_we;
	logic [2:0]            rf_idx;
	logic [7:0]            rf_wd;
	cms_pkg::kind_t        kind;
	logic                  is_call;
	logic [15:0]           pc_res;

	logic [15:0]           res_pc;
	logic [15:0]           res_val;

	assign accept  = s_tvalid && s_tready;
	assign s1_long = s1_valid_s1 && (call_s1 || kind_s1 == cms_pkg::KIND_LOAD);
	assign s_tready = !s1_long &&
		((out_cnt == 2'd0) || (out_cnt == 2'd1 && !s1_valid_s1));

	// decode and first-stage RAM requests
	always_comb begin
		src     = opcode[2:0];
		dst     = opcode[5:3];
		hl      = {regs_q[cms_pkg::REG_H], regs_q[cms_pkg::REG_L]};
		a_req0  = '{we: 1'b0, addr: hl, wdata: regs_q[src]};
		a_req1  = '{we: 1'b0, addr: sp_q + 16'd1, wdata: data_high};
		sp_nxt  = sp_q;
		flg_nxt = flags_q;
		rf_we   = 1'b0;
		rf_idx  = dst;
		rf_wd   = regs_q[src];
		kind    = cms_pkg::KIND_NONE;
		is_call = 1'b0;
		pc_res  = pc_in;
		case (mode)
			cms_pkg::MODE_MOV: begin
				if (src == cms_pkg::HL_SLOT && dst == cms_pkg::HL_SLOT) begin
					kind = cms_pkg::KIND_NONE;
				end else if (src == cms_pkg::HL_SLOT) begin
					kind = cms_pkg::KIND_LOAD;
				end else if (dst == cms_pkg::HL_SLOT) begin
					a_req0.we = 1'b1;
				end else begin
					rf_we = 1'b1;
				end
			end
			cms_pkg::MODE_PUSH: begin
				a_req0 = '{we: 1'b1, addr: sp_q - 16'd1, wdata: data_high};
				a_req1 = '{we: 1'b1, addr: sp_q - 16'd2, wdata: data_low};
				sp_nxt = sp_q - 16'd2;
			end
			cms_pkg::MODE_POP: begin
				a_req0.addr = sp_q;
				a_req1.addr = sp_q + 16'd1;
				kind        = cms_pkg::KIND_POP;
				sp_nxt      = sp_q + 16'd2;
			end
			cms_pkg::MODE_CALL: begin
				a_req0.addr = pc_in;
				a_req1.addr = pc_in + 16'd1;
				kind        = cms_pkg::KIND_TARGET;
				is_call     = 1'b1;
				sp_nxt      = sp_q - 16'd2;
				pc_res      = pc_in + 16'd2;
			end
			cms_pkg::MODE_JMP: begin
				a_req0.addr = pc_in;
				a_req1.addr = pc_in + 16'd1;
				kind        = cms_pkg::KIND_TARGET;
			end
			cms_pkg::MODE_RST: begin
				a_req0 = '{we: 1'b1, addr: sp_q - 16'd1, wdata: pc_in[15:8]};
				a_req1 = '{we: 1'b1, addr: sp_q - 16'd2, wdata: pc_in[7:0]};
				sp_nxt = sp_q - 16'd2;
				pc_res = {10'd0, restart_number, 3'd0};
			end
			cms_pkg::MODE_FLAG_LD: begin
				flg_nxt = cms_pkg::unpack_flags(data_low);
			end
			cms_pkg::MODE_MEM_WR: begin
				a_req0 = '{we: 1'b1, addr: write_address, wdata: data_low};
			end
			cms_pkg::MODE_REG_WR: begin
				rf_we  = 1'b1;
				rf_idx = reg_index;
				rf_wd  = data_low;
			end
			default: begin
				kind = cms_pkg::KIND_NONE;
			end
		endcase
	end

	// a CALL in stage 1 owns both ports for its return-address writes
	always_comb begin
		if (s1_valid_s1 && call_s1) begin
			req0 = '{we: 1'b1, addr: sp_s1 + 16'd1, wdata: pc_s1[15:8]};
			req1 = '{we: 1'b1, addr: sp_s1, wdata: pc_s1[7:0]};
		end else begin
			req0    = a_req0;
			req1    = a_req1;
			req0.we = a_req0.we && accept;
			req1.we = a_req1.we && accept;
		end
	end

	cms_ram #(
		.ADDR_BITS(ADDR_BITS)
	) u_ram (
		.clk   (clk),
		.req0  (req0),
		.req1  (req1),
		.rdata0(rdata0),
		.rdata1(rdata1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				regs_q[i] <= 8'd0;
			end
			sp_q        <= 16'd0;
			flags_q     <= 5'd0;
			s1_valid_s1 <= 1'b0;
		end else begin
			s1_valid_s1 <= accept;
			if (accept) begin
				sp_q    <= sp_nxt;
				flags_q <= flg_nxt;
				if (rf_we) begin
					regs_q[rf_idx] <= rf_wd;
				end
			end
			if (s1_valid_s1 && kind_s1 == cms_pkg::KIND_LOAD) begin
				regs_q[dst_s1] <= rdata0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			call_s1 <= is_call;
			kind_s1 <= kind;
			dst_s1  <= dst;
			pc_s1   <= pc_res;
			sp_s1   <= sp_nxt;
			flg_s1  <= cms_pkg::pack_flags(flg_nxt);
		end
	end

	assign res_pc  = (kind_s1 == cms_pkg::KIND_TARGET) ? {rdata1, rdata0} : pc_s1;
	assign res_val = (kind_s1 == cms_pkg::KIND_POP) ? {rdata1, rdata0} : 16'd0;

	cms_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s1_valid_s1),
		.push_data ({sp_s1, flg_s1, res_val, res_pc}),
		.take_ready(m_tready),
		.valid     (m_tvalid),
		.data      (m_tdata),
		.count     (out_cnt)
	);

`ifndef SYNTH
	a_no_accept_when_long: assert property (@(posedge clk) disable iff (!arst_n)
		s1_long |-> !accept)
		else $error("input transfer during second cycle of call or load");

	a_ports_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		req0.we && req1.we |-> req0.addr != req1.addr)
		else $error("both RAM ports write one address");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && !(m_tvalid && m_tready) |-> out_cnt != 2'd2)
		else $error("result pushed into full output queue");

	a_call_writes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode == cms_pkg::MODE_CALL |=> req0.we && req1.we)
		else $error("call return address not written");
`endif

endmodule

`default_nettype wire

// ===== test/tb_cpu8080_move_stack_unit_core.sv =====
module tb_cpu8080_move_stack_unit_core;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1600;

	localparam logic [2:0] REG_B = 3'd0;
	localparam logic [2:0] REG_A = 3'd7;

	// modes with no defined operation
	localparam logic [3:0] MODE_UNUSED_LO = 4'd10;
	localparam logic [3:0] MODE_UNUSED_HI = 4'd15;

	typedef struct {
		logic [3:0]  mode;
		logic [7:0]  opcode;
		logic [15:0] pc;
		logic [7:0]  data_high;
		logic [7:0]  data_low;
		logic [2:0]  restart_number;
		logic [15:0] write_address;
		logic [2:0]  reg_index;
	} move_item_t;

	typedef struct {
		logic [15:0] pc;
		logic [15:0] value;
		logic [7:0]  flags;
		logic [15:0] sp;
	} move_result_t;

	typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_CYCLIC} ready_style_t;

	logic                       clk;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	// opcode, pc_in, data_high, data_low, restart_number, write_address, reg_index, pad
	logic [cms_pkg::IN_W-1:0]   s_tdata;
	// mode
	logic [cms_pkg::USER_W-1:0] s_tuser;
	logic                       m_tvalid;
	logic                       m_tready;
	// pc_out, value_out, flag_byte_out, stack_pointer_out
	logic [cms_pkg::OUT_W-1:0]  m_tdata;

	// predicted machine state
	logic [7:0]  mem_image [0:65535];
	bit          mem_written [0:65535];
	logic [7:0]  reg_file [0:7];
	logic [15:0] stack_ptr;
	logic [4:0]  flag_state;

	move_result_t pending_results[$];
	int           error_count = 0;
	int           sent_count;
	int           burst_left;
	int           cycle_count = 0;
	int           ready_run;
	ready_style_t ready_style;

	cpu8080_move_stack_unit_core #(
		.ADDR_BITS(16)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// S Z AC P CY held internally, S Z 1 AC 0 P 1 CY on the wire
	function automatic logic [7:0] flags_to_byte(logic [4:0] f);
		return {f[4], f[3], 1'b1, f[2], 1'b0, f[1], 1'b1, f[0]};
	endfunction

	function automatic void store_byte(logic [15:0] addr, logic [7:0] data);
		mem_image[addr]   = data;
		mem_written[addr] = 1'b1;
	endfunction

	// high byte goes first so the word sits little-endian
	function automatic void push_word(logic [15:0] w);
		stack_ptr = stack_ptr - 16'd1;
		store_byte(stack_ptr, w[15:8]);
		stack_ptr = stack_ptr - 16'd1;
		store_byte(stack_ptr, w[7:0]);
	endfunction

	function automatic move_result_t step_move_stack(move_item_t it);
		move_result_t r;
		logic [2:0]   src;
		logic [2:0]   dst;
		logic [15:0]  hl;
		logic [15:0]  pc_plus1;
		logic [15:0]  sp_plus1;
		logic [15:0]  target;
		src      = it.opcode[2:0];
		dst      = it.opcode[5:3];
		hl       = {reg_file[cms_pkg::REG_H], reg_file[cms_pkg::REG_L]};
		pc_plus1 = it.pc + 16'd1;
		sp_plus1 = stack_ptr + 16'd1;
		// target fetched before any push can overwrite it
		target   = {mem_image[pc_plus1], mem_image[it.pc]};
		r.pc     = it.pc;
		r.value  = '0;
		case (it.mode)
		cms_pkg::MODE_MOV: begin
			// M to M falls through all three arms
			if (src == cms_pkg::HL_SLOT && dst != cms_pkg::HL_SLOT)
				reg_file[dst] = mem_image[hl];
			else if (dst == cms_pkg::HL_SLOT && src != cms_pkg::HL_SLOT)
				store_byte(hl, reg_file[src]);
			else if (src != cms_pkg::HL_SLOT)
				reg_file[dst] = reg_file[src];
		end
		cms_pkg::MODE_PUSH: push_word({it.data_high, it.data_low});
		cms_pkg::MODE_POP: begin
			r.value   = {mem_image[sp_plus1], mem_image[stack_ptr]};
			stack_ptr = stack_ptr + 16'd2;
		end
		cms_pkg::MODE_CALL: begin
			push_word(it.pc + 16'd2);
			r.pc = target;
		end
		cms_pkg::MODE_JMP: r.pc = target;
		cms_pkg::MODE_RST: begin
			push_word(it.pc);
			r.pc = {10'd0, it.restart_number, 3'd0};
		end
		cms_pkg::MODE_FLAG_LD: flag_state = {it.data_low[7], it.data_low[6],
			it.data_low[4], it.data_low[2], it.data_low[0]};
		cms_pkg::MODE_MEM_WR: store_byte(it.write_address, it.data_low);
		cms_pkg::MODE_REG_WR: reg_file[it.reg_index] = it.data_low;
		default: ;
		endcase
		r.flags = flags_to_byte(flag_state);
		r.sp    = stack_ptr;
		return r;
	endfunction

	function automatic move_item_t random_item(logic [3:0] mode);
		move_item_t it;
		it.mode           = mode;
		it.opcode         = 8'($urandom_range(0, 255));
		it.pc             = 16'($urandom_range(0, 65535));
		it.data_high      = 8'($urandom_range(0, 255));
		it.data_low       = 8'($urandom_range(0, 255));
		it.restart_number = 3'($urandom_range(0, 7));
		it.write_address  = 16'($urandom_range(0, 65535));
		it.reg_index      = 3'($urandom_range(0, 7));
		return it;
	endfunction

	function automatic logic [3:0] pick_mode();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return 4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
		else if (r < 30)
			return cms_pkg::MODE_MOV;
		return 4'($urandom_range(cms_pkg::MODE_MOV, cms_pkg::MODE_REG_WR));
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			error_count++;
		end
	endfunction

	task automatic issue_op(move_item_t it);
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = it.mode;
		s_tdata  = {2'b00, it.reg_index, it.write_address, it.restart_number,
			it.data_low, it.data_high, it.pc, it.opcode};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(step_move_stack(it));
		sent_count++;
		burst_left--;
		if (burst_left <= 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	task automatic write_mem(logic [15:0] addr, logic [7:0] data);
		move_item_t it;
		it               = random_item(cms_pkg::MODE_MEM_WR);
		it.write_address = addr;
		it.data_low      = data;
		issue_op(it);
	endtask

	task automatic set_reg(logic [2:0] idx, logic [7:0] data);
		move_item_t it;
		it           = random_item(cms_pkg::MODE_REG_WR);
		it.reg_index = idx;
		it.data_low  = data;
		issue_op(it);
	endtask

	// memory is undefined until written, so fill any byte the op would read
	task automatic run_op(move_item_t it);
		logic [15:0] reads[$];
		case (it.mode)
		cms_pkg::MODE_MOV:
			if (it.opcode[2:0] == cms_pkg::HL_SLOT && it.opcode[5:3] != cms_pkg::HL_SLOT)
				reads.push_back({reg_file[cms_pkg::REG_H], reg_file[cms_pkg::REG_L]});
		cms_pkg::MODE_POP: begin
			reads.push_back(stack_ptr);
			reads.push_back(stack_ptr + 16'd1);
		end
		cms_pkg::MODE_CALL, cms_pkg::MODE_JMP: begin
			reads.push_back(it.pc);
			reads.push_back(it.pc + 16'd1);
		end
		default: ;
		endcase
		foreach (reads[i])
			if (!mem_written[reads[i]])
				write_mem(reads[i], 8'($urandom_range(0, 255)));
		issue_op(it);
	endtask

	task automatic drain_pipeline();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed_ops();
		move_item_t it;
		run_op(random_item(cms_pkg::MODE_FLAG_RD));
		run_op(random_item(MODE_UNUSED_LO));
		run_op(random_item(MODE_UNUSED_HI));
		it = random_item(cms_pkg::MODE_FLAG_LD);
		it.data_low = 8'hFF;
		run_op(it);
		it.data_low = 8'h00;
		run_op(it);
		set_reg(cms_pkg::REG_H, 8'hFF);
		set_reg(cms_pkg::REG_L, 8'hFF);
		set_reg(REG_A, 8'h5A);
		it = random_item(cms_pkg::MODE_MOV);
		it.opcode = {2'b01, cms_pkg::HL_SLOT, REG_A};
		run_op(it);
		it.opcode = {2'b01, REG_B, cms_pkg::HL_SLOT};
		run_op(it);
		it.opcode = {2'b01, cms_pkg::HL_SLOT, cms_pkg::HL_SLOT};
		run_op(it);
		// top opcode bits must be ignored
		it.opcode = {2'b11, REG_A, REG_B};
		run_op(it);
		// stack pointer wraps below zero and back
		it = random_item(cms_pkg::MODE_PUSH);
		{it.data_high, it.data_low} = 16'hFFFF;
		run_op(it);
		{it.data_high, it.data_low} = 16'h0000;
		run_op(it);
		run_op(random_item(cms_pkg::MODE_POP));
		run_op(random_item(cms_pkg::MODE_POP));
		// target straddles the top of the address space
		write_mem(16'h0000, 8'h34);
		it = random_item(cms_pkg::MODE_CALL);
		it.pc = 16'hFFFF;
		run_op(it);
		run_op(random_item(cms_pkg::MODE_POP));
		it.mode = cms_pkg::MODE_JMP;
		run_op(it);
		it = random_item(cms_pkg::MODE_RST);
		it.pc = 16'h0000;
		it.restart_number = 3'd0;
		run_op(it);
		it.pc = 16'hFFFF;
		it.restart_number = 3'd7;
		run_op(it);
		run_op(random_item(cms_pkg::MODE_POP));
		run_op(random_item(cms_pkg::MODE_POP));
		set_reg(REG_B, 8'h00);
	endtask

	task automatic test_random_traffic(int count);
		move_item_t  it;
		int          start;
		int          depth;
		logic [15:0] addr;
		start = sent_count;
		while (sent_count - start < count) begin
			case ($urandom_range(0, 5))
			0, 1: run_op(random_item(pick_mode()));
			2: begin
				depth = $urandom_range(1, 4);
				repeat (depth) run_op(random_item(cms_pkg::MODE_PUSH));
				if ($urandom_range(0, 1))
					run_op(random_item(pick_mode()));
				repeat (depth) run_op(random_item(cms_pkg::MODE_POP));
			end
			3: begin
				// subroutine entry, then return address popped
				run_op(random_item($urandom_range(0, 1) ? cms_pkg::MODE_CALL
					: cms_pkg::MODE_RST));
				run_op(random_item(cms_pkg::MODE_POP));
			end
			4: begin
				set_reg(cms_pkg::REG_H, 8'($urandom_range(0, 255)));
				set_reg(cms_pkg::REG_L, 8'($urandom_range(0, 255)));
				it = random_item(cms_pkg::MODE_MOV);
				it.opcode[5:3] = cms_pkg::HL_SLOT;
				run_op(it);
				it = random_item(cms_pkg::MODE_MOV);
				it.opcode[2:0] = cms_pkg::HL_SLOT;
				run_op(it);
			end
			default: begin
				addr = 16'($urandom_range(0, 65535));
				write_mem(addr, 8'($urandom_range(0, 255)));
				write_mem(addr + 16'd1, 8'($urandom_range(0, 255)));
				it = random_item($urandom_range(0, 1) ? cms_pkg::MODE_JMP
					: cms_pkg::MODE_CALL);
				it.pc = addr;
				run_op(it);
			end
			endcase
		end
	endtask

	// receiver stall pattern, changes style after each random run
	initial begin
		m_tready  = 1'b0;
		ready_run = 0;
		forever begin
			@(negedge clk);
			if (ready_run == 0) begin
				ready_style = ready_style_t'($urandom_range(0, 3));
				ready_run   = $urandom_range(8, 60);
			end
			ready_run--;
			case (ready_style)
			READY_ALWAYS: m_tready = 1'b1;
			READY_COIN:   m_tready = 1'($urandom_range(0, 1));
			READY_SPARSE: m_tready = ($urandom_range(0, 4) == 0);
			default:      m_tready = (ready_run % 3 != 0);
			endcase
		end
	end

	always @(posedge clk) begin : result_check
		move_result_t got;
		move_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.pc    = m_tdata[15:0];
			got.value = m_tdata[31:16];
			got.flags = m_tdata[39:32];
			got.sp    = m_tdata[55:40];
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing outstanding: %h", m_tdata);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("pc_out", want.pc, got.pc);
				check_field("value_out", want.value, got.value);
				check_field("flag_byte_out", {8'h00, want.flags}, {8'h00, got.flags});
				check_field("stack_pointer_out", want.sp, got.sp);
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		sent_count  = 0;
		burst_left  = 20;
		stack_ptr   = '0;
		flag_state  = '0;
		foreach (reg_file[i])
			reg_file[i] = 8'h00;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_ops();
		drain_pipeline();
		test_random_traffic(RANDOM_ITEMS / 2);
		drain_pipeline();
		test_random_traffic(RANDOM_ITEMS / 2);
		drain_pipeline();
		repeat (20) @(posedge clk);

		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
